// File: hw/rtl/fic_pkg.sv
// ----------------------------------------------------------------------------
// fic_pkg: shared types and constants for the Fresnel integral pair core
// Fixed-point word type, scale constants in Q.48, pipeline latencies.
// ----------------------------------------------------------------------------
package fic_pkg;

  // internal fixed point: signed Q.48 held in a 64-bit two's complement word
  localparam int unsigned WORD_W = 64;
  localparam int unsigned IFB    = 48;

  typedef logic [WORD_W-1:0] word_t;

  localparam int unsigned NUM_TERMS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned FIELD_W_DEF   = FRAC_BITS_DEF + 2;

  // pi scaled by 2^60, rounded to nearest in Q.48
  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam word_t       SCALE_Q  = word_t'((PI_Q60 + (64'd1 << 11)) >> 12);
  localparam logic [127:0] SCALE_SQ_P = 128'(SCALE_Q) * 128'(SCALE_Q)
                                        + (128'd1 << (IFB - 1));
  localparam word_t       SCALE_SQ = SCALE_SQ_P[IFB +: WORD_W];

  // latencies in cycles of the arithmetic units
  localparam int unsigned MUL_LAT  = 4;
  localparam int unsigned DIV_LAT  = 6;
  localparam int unsigned TERM_LAT = MUL_LAT + 1 + DIV_LAT;
  localparam int unsigned PRE_LAT  = 1 + 3 * MUL_LAT;
  localparam int unsigned POST_LAT = 2;

endpackage

// File: hw/rtl/fic_if.sv
// ----------------------------------------------------------------------------
// fic_if: valid/ready channels of the Fresnel integral pair core
// Argument channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface fic_in_if #(
  parameter int unsigned FW = fic_pkg::FIELD_W_DEF
);
  logic          valid;
  logic          ready;
  logic [FW-1:0] arg_u;

  modport source (output valid, output arg_u, input ready);
  modport sink   (input valid, input arg_u, output ready);
endinterface

interface fic_out_if #(
  parameter int unsigned FW = fic_pkg::FIELD_W_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [FW-1:0] cos_integral;
  logic signed [FW-1:0] sin_integral;

  modport source (output valid, output cos_integral, output sin_integral, input ready);
  modport sink   (input valid, input cos_integral, input sin_integral, output ready);
endinterface

// File: hw/rtl/fic_dly.sv
// ----------------------------------------------------------------------------
// fic_dly: stall-aware delay line
// Shifts a word through N registers while the pipeline advances.
// ----------------------------------------------------------------------------
module fic_dly #(
  parameter int unsigned W = fic_pkg::WORD_W,
  parameter int unsigned N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

// File: hw/rtl/fic_umul.sv
// ----------------------------------------------------------------------------
// fic_umul: two-stage unsigned 64x64 multiplier with scaled output
// Four 32x32 partial products, then one summing stage that adds an optional
// rounding constant and keeps 64 bits starting at bit SHIFT.
// ----------------------------------------------------------------------------
module fic_umul #(
  parameter int unsigned SHIFT = fic_pkg::IFB,
  parameter bit          RND   = 1'b1
) (
  input  logic          clk,
  input  logic          en,
  input  fic_pkg::word_t a,
  input  fic_pkg::word_t b,
  output fic_pkg::word_t p
);

  localparam logic [127:0] RND_ADD = RND ? (128'd1 << (SHIFT - 1)) : 128'd0;

  logic [63:0]    pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [127:0]   sum;
  fic_pkg::word_t p_r;

  assign sum = {64'd0, pp_ll_r} + {32'd0, pp_lh_r, 32'd0} + {32'd0, pp_hl_r, 32'd0}
             + {pp_hh_r, 64'd0} + RND_ADD;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= {32'd0, a[31:0]}  * {32'd0, b[31:0]};
      pp_lh_r <= {32'd0, a[31:0]}  * {32'd0, b[63:32]};
      pp_hl_r <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
      pp_hh_r <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
      p_r     <= sum[SHIFT +: 64];
    end
  end

  assign p = p_r;

endmodule

// File: hw/rtl/fic_mul.sv
// ----------------------------------------------------------------------------
// fic_mul: signed Q.48 multiply, rounded half away from zero
// Magnitudes, unsigned product, then the sign is put back (64-bit wrap).
// ----------------------------------------------------------------------------
module fic_mul (
  input  logic          clk,
  input  logic          en,
  input  fic_pkg::word_t a,
  input  fic_pkg::word_t b,
  output fic_pkg::word_t p
);

  fic_pkg::word_t ma_r, mb_r, mag_p, p_r;
  logic           neg_r;
  logic [1:0]     neg_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r    <= a[63] ? (~a + 64'd1) : a;
      mb_r    <= b[63] ? (~b + 64'd1) : b;
      neg_r   <= a[63] ^ b[63];
      neg_d_r <= {neg_d_r[0], neg_r};
      p_r     <= neg_d_r[1] ? (~mag_p + 64'd1) : mag_p;
    end
  end

  fic_umul #(.SHIFT(fic_pkg::IFB), .RND(1'b1)) u_umul (
    .clk (clk),
    .en  (en),
    .a   (ma_r),
    .b   (mb_r),
    .p   (mag_p)
  );

  assign p = p_r;

endmodule

// File: hw/rtl/fic_div.sv
// ----------------------------------------------------------------------------
// fic_div: divide by a constant, rounded half away from zero
// Reciprocal multiply gives the quotient or one less; one correction step
// fixes it. Divide by one passes the value through.
// ----------------------------------------------------------------------------
module fic_div #(
  parameter int unsigned D = 3
) (
  input  logic          clk,
  input  logic          en,
  input  fic_pkg::word_t a,
  output fic_pkg::word_t y
);

  if (D == 1) begin : g_unit
    fic_dly #(.W(fic_pkg::WORD_W), .N(fic_pkg::DIV_LAT)) u_dly (
      .clk (clk),
      .en  (en),
      .d   (a),
      .q   (y)
    );
  end else begin : g_div
    localparam logic [127:0] RECIP_W = (128'd1 << 64) / D;
    localparam fic_pkg::word_t RECIP = RECIP_W[63:0];
    localparam fic_pkg::word_t DC    = 64'(D);
    localparam fic_pkg::word_t HALFD = 64'(D / 2);

    fic_pkg::word_t n_r, q0, q0_r, qd_r, n3_r, q4_r, y_r;
    fic_pkg::word_t n_d_r [2];
    logic [2:0]     neg_d_r;
    logic           neg_r, neg3_r, neg4_r;

    always_ff @(posedge clk) begin
      if (en) begin
        n_r      <= (a[63] ? (~a + 64'd1) : a) + HALFD;
        neg_r    <= a[63];
        n_d_r[0] <= n_r;
        n_d_r[1] <= n_d_r[0];
        neg_d_r  <= {neg_d_r[1:0], neg_r};
        // quotient estimate is exact or one short
        qd_r     <= q0 * DC;
        q0_r     <= q0;
        n3_r     <= n_d_r[1];
        neg3_r   <= neg_d_r[1];
        q4_r     <= ((n3_r - qd_r) >= DC) ? (q0_r + 64'd1) : q0_r;
        neg4_r   <= neg3_r;
        y_r      <= neg4_r ? (~q4_r + 64'd1) : q4_r;
      end
    end

    fic_umul #(.SHIFT(64), .RND(1'b0)) u_recip (
      .clk (clk),
      .en  (en),
      .a   (n_r),
      .b   (RECIP),
      .p   (q0)
    );

    assign y = y_r;
  end

endmodule

// File: hw/rtl/fic_term.sv
// ----------------------------------------------------------------------------
// fic_term: one series term of the pair
// Adds ct/(4k+1) and st/(4k+3) into the sums and forms the next ct and st
// by multiplying by -x and dividing by two consecutive integers.
// ----------------------------------------------------------------------------
module fic_term #(
  parameter int unsigned K = 0
) (
  input  logic          clk,
  input  logic          en,
  input  fic_pkg::word_t ct_i,
  input  fic_pkg::word_t st_i,
  input  fic_pkg::word_t x_i,
  input  fic_pkg::word_t cs_i,
  input  fic_pkg::word_t ss_i,
  output fic_pkg::word_t ct_o,
  output fic_pkg::word_t st_o,
  output fic_pkg::word_t x_o,
  output fic_pkg::word_t cs_o,
  output fic_pkg::word_t ss_o
);

  localparam int unsigned D_CS = 4 * K + 1;
  localparam int unsigned D_SS = 4 * K + 3;
  localparam int unsigned D_CT = (2 * K + 1) * (2 * K + 2);
  localparam int unsigned D_ST = (2 * K + 2) * (2 * K + 3);
  localparam int unsigned ACC_HOLD = fic_pkg::TERM_LAT - fic_pkg::DIV_LAT - 1;

  fic_pkg::word_t pc, ps, nc_r, ns_r, qc, qs, cs_d, ss_d, cs_r, ss_r;

  // next terms: negate the product, then divide
  fic_mul u_mul_c (.clk(clk), .en(en), .a(ct_i), .b(x_i), .p(pc));
  fic_mul u_mul_s (.clk(clk), .en(en), .a(st_i), .b(x_i), .p(ps));

  always_ff @(posedge clk) begin
    if (en) begin
      nc_r <= ~pc + 64'd1;
      ns_r <= ~ps + 64'd1;
      cs_r <= cs_d + qc;
      ss_r <= ss_d + qs;
    end
  end

  fic_div #(.D(D_CT)) u_div_ct (.clk(clk), .en(en), .a(nc_r), .y(ct_o));
  fic_div #(.D(D_ST)) u_div_st (.clk(clk), .en(en), .a(ns_r), .y(st_o));

  // sum updates
  fic_div #(.D(D_CS)) u_div_cs (.clk(clk), .en(en), .a(ct_i), .y(qc));
  fic_div #(.D(D_SS)) u_div_ss (.clk(clk), .en(en), .a(st_i), .y(qs));

  fic_dly #(.W(fic_pkg::WORD_W), .N(fic_pkg::DIV_LAT)) u_cs_in (
    .clk(clk), .en(en), .d(cs_i), .q(cs_d));
  fic_dly #(.W(fic_pkg::WORD_W), .N(fic_pkg::DIV_LAT)) u_ss_in (
    .clk(clk), .en(en), .d(ss_i), .q(ss_d));
  fic_dly #(.W(fic_pkg::WORD_W), .N(ACC_HOLD)) u_cs_out (
    .clk(clk), .en(en), .d(cs_r), .q(cs_o));
  fic_dly #(.W(fic_pkg::WORD_W), .N(ACC_HOLD)) u_ss_out (
    .clk(clk), .en(en), .d(ss_r), .q(ss_o));
  fic_dly #(.W(fic_pkg::WORD_W), .N(fic_pkg::TERM_LAT)) u_x (
    .clk(clk), .en(en), .d(x_i), .q(x_o));

endmodule

// File: hw/rtl/fresnel_integral_pair_core.sv
// ----------------------------------------------------------------------------
// fresnel_integral_pair_core: pipelined Fresnel C(u) and S(u)
// Power series in x = scale^2 * u^4, one term stage per series term.
//
//   Channel  Dir  Payload                                   Beat on
//   in_ch    in   arg_u (unsigned Q2.FRAC_BITS)             valid & ready
//   out_ch   out  cos_integral, sin_integral (signed Q1.F)  valid & ready
//
// The pipeline forms u^2, u^4 and x, then each term stage multiplies, negates
// and divides by constants, and the sums are rounded and saturated at the end.
// One beat per cycle is taken while the two-entry output buffer has room.
// A full buffer freezes the whole pipeline; bubbles and beats hold in place.
// Reset is synchronous and clears only valid bits and the buffer state.
// ----------------------------------------------------------------------------
module fresnel_integral_pair_core #(
  parameter int unsigned NUM_TERMS = fic_pkg::NUM_TERMS_DEF,
  parameter int unsigned FRAC_BITS = fic_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fic_in_if.sink    in_ch,
  fic_out_if.source out_ch
);

  localparam int unsigned FW    = FRAC_BITS + 2;
  localparam int unsigned SH    = fic_pkg::IFB - FRAC_BITS;
  localparam int unsigned LAT   = fic_pkg::PRE_LAT + fic_pkg::TERM_LAT * NUM_TERMS
                                  + fic_pkg::POST_LAT;
  localparam logic [FW-1:0]  TWO_Q   = FW'(1) << (FRAC_BITS + 1);
  localparam logic [FW-1:0]  MIN_F   = FW'(1) << (FW - 1);
  localparam fic_pkg::word_t MAXV    = (64'd1 << (FRAC_BITS + 1)) - 64'd1;
  localparam fic_pkg::word_t RND_OUT = 64'd1 << (SH - 1);

  function automatic logic [FW-1:0] sat_field(input logic neg, input fic_pkg::word_t abs_v);
    fic_pkg::word_t m;
    logic [FW-1:0]  res;
    m = (abs_v + RND_OUT) >> SH;
    if (!neg) begin
      res = (m > MAXV) ? MAXV[FW-1:0] : m[FW-1:0];
    end else begin
      res = (m > MAXV + 64'd1) ? MIN_F : ((~m[FW-1:0]) + FW'(1));
    end
    return res;
  endfunction

  logic           en, push, pop;
  logic [LAT-1:0] vld_r;
  logic [FW-1:0]  uq;
  fic_pkg::word_t u_r, u2, u4, u3, u_d4, x0, st0, ct0;
  fic_pkg::word_t ct_a [NUM_TERMS+1];
  fic_pkg::word_t st_a [NUM_TERMS+1];
  fic_pkg::word_t x_a  [NUM_TERMS+1];
  fic_pkg::word_t cs_a [NUM_TERMS+1];
  fic_pkg::word_t ss_a [NUM_TERMS+1];
  logic           c_neg_r, s_neg_r;
  fic_pkg::word_t c_abs_r, s_abs_r;
  logic [FW-1:0]  cos_r, sin_r;
  logic [FW-1:0]  c_slot0_r, c_slot1_r, s_slot0_r, s_slot1_r;
  logic [1:0]     cnt_r;
  logic           wr_ptr_r, rd_ptr_r;

  assign en   = (cnt_r != 2'd2);
  assign push = en & vld_r[LAT-1];
  assign pop  = (cnt_r != 2'd0) & out_ch.ready;

  assign in_ch.ready = en;

  // argument: clamp to 2.0, move to Q.48
  assign uq = (in_ch.arg_u > TWO_Q) ? TWO_Q : in_ch.arg_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= fic_pkg::word_t'(uq) << SH;
    end
  end

  fic_mul u_mul_u2 (.clk(clk), .en(en), .a(u_r), .b(u_r), .p(u2));
  fic_dly #(.W(fic_pkg::WORD_W), .N(fic_pkg::MUL_LAT)) u_dly_u (
    .clk(clk), .en(en), .d(u_r), .q(u_d4));
  fic_mul u_mul_u4 (.clk(clk), .en(en), .a(u2), .b(u2), .p(u4));
  fic_mul u_mul_u3 (.clk(clk), .en(en), .a(u2), .b(u_d4), .p(u3));
  fic_mul u_mul_x  (.clk(clk), .en(en), .a(fic_pkg::SCALE_SQ), .b(u4), .p(x0));
  fic_mul u_mul_s0 (.clk(clk), .en(en), .a(fic_pkg::SCALE_Q), .b(u3), .p(st0));
  fic_dly #(.W(fic_pkg::WORD_W), .N(fic_pkg::PRE_LAT - 1)) u_dly_c0 (
    .clk(clk), .en(en), .d(u_r), .q(ct0));

  assign ct_a[0] = ct0;
  assign st_a[0] = st0;
  assign x_a[0]  = x0;
  assign cs_a[0] = '0;
  assign ss_a[0] = '0;

  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
    fic_term #(.K(k)) u_term (
      .clk  (clk),
      .en   (en),
      .ct_i (ct_a[k]),
      .st_i (st_a[k]),
      .x_i  (x_a[k]),
      .cs_i (cs_a[k]),
      .ss_i (ss_a[k]),
      .ct_o (ct_a[k+1]),
      .st_o (st_a[k+1]),
      .x_o  (x_a[k+1]),
      .cs_o (cs_a[k+1]),
      .ss_o (ss_a[k+1])
    );
  end

  // round the sums to the output format and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      c_neg_r <= cs_a[NUM_TERMS][63];
      s_neg_r <= ss_a[NUM_TERMS][63];
      c_abs_r <= cs_a[NUM_TERMS][63] ? (~cs_a[NUM_TERMS] + 64'd1) : cs_a[NUM_TERMS];
      s_abs_r <= ss_a[NUM_TERMS][63] ? (~ss_a[NUM_TERMS] + 64'd1) : ss_a[NUM_TERMS];
      cos_r   <= sat_field(c_neg_r, c_abs_r);
      sin_r   <= sat_field(s_neg_r, s_abs_r);
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (wr_ptr_r) begin
        c_slot1_r <= cos_r;
        s_slot1_r <= sin_r;
      end else begin
        c_slot0_r <= cos_r;
        s_slot0_r <= sin_r;
      end
    end
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.cos_integral = $signed(rd_ptr_r ? c_slot1_r : c_slot0_r);
  assign out_ch.sin_integral = $signed(rd_ptr_r ? s_slot1_r : s_slot0_r);

endmodule

// File: hw/rtl/fic_chk.sv
// ----------------------------------------------------------------------------
// fic_chk: port-level checks for the Fresnel integral pair core
// Watches the handshakes on the top level and flags buffer misbehavior.
// ----------------------------------------------------------------------------
module fic_chk #(
  parameter int unsigned FW = fic_pkg::FIELD_W_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [FW-1:0] cos_integral,
  input logic [FW-1:0] sin_integral
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cos_integral) && $stable(sin_integral))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an empty buffer always leaves room for input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input ready dropped without an output stall");

endmodule

bind fresnel_integral_pair_core fic_chk #(.FW(FRAC_BITS + 2)) u_fic_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .cos_integral (out_ch.cos_integral),
  .sin_integral (out_ch.sin_integral)
);

// File: tb/fresnel_integral_pair_core_test.sv
// ----------------------------------------------------------------------------
// fresnel_integral_pair_core_test: self-checking bench for the Fresnel core
// Drives directed arguments, then arguments in random bursts, and predicts C(u)
// and S(u) in Q.48 fixed point. Compares every result beat in order, with the sink stalling at times.
// ----------------------------------------------------------------------------
module fresnel_integral_pair_core_test;

  localparam int unsigned FW    = fic_pkg::FIELD_W_DEF;
  localparam int unsigned FB    = fic_pkg::FRAC_BITS_DEF;
  localparam int unsigned NT    = fic_pkg::NUM_TERMS_DEF;
  localparam int unsigned QB    = fic_pkg::IFB;
  localparam int unsigned LAT   = 15 + 11 * NT;
  localparam int unsigned N_RND = 830;

  typedef struct packed {
    logic signed [FW-1:0] c;
    logic signed [FW-1:0] s;
  } fresnel_pair_t;

  // exact product rounded half away from zero to Q.48
  function automatic longint qmul(longint a, longint b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] p;
    logic [63:0]  r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = 128'(ma) * 128'(mb) + (128'd1 << (QB - 1));
    r = p[QB +: 64];
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint qdiv(longint a, longint d);
    logic [63:0] m;
    logic [63:0] r;
    m = a < 0 ? -a : a;
    r = (m + 64'(d) / 2) / 64'(d);
    return a < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [FW-1:0] round_to_field(longint sum);
    logic [63:0] m;
    longint      v;
    longint      maxv;
    m = ((sum < 0 ? -sum : sum) + (64'd1 << (QB - FB - 1))) >> (QB - FB);
    v = sum < 0 ? -longint'(m) : longint'(m);
    maxv = (longint'(1) << (FB + 1)) - 1;
    if (v > maxv) v = maxv;
    if (v < -maxv - 1) v = -maxv - 1;
    return v[FW-1:0];
  endfunction

  function automatic fresnel_pair_t fresnel_series(logic [FW-1:0] arg);
    logic [63:0]   uq;
    longint        u;
    longint        h;
    longint        u2;
    longint        x;
    longint        ct;
    longint        st;
    longint        csum;
    longint        ssum;
    fresnel_pair_t r;
    uq = 64'(arg);
    if (uq > (64'd1 << (FB + 1))) uq = 64'd1 << (FB + 1);
    u = longint'(uq << (QB - FB));
    h = longint'((fic_pkg::PI_Q60 + (64'd1 << 11)) >> 12);
    u2 = qmul(u, u);
    x = qmul(qmul(h, h), qmul(u2, u2));
    ct = u;
    st = qmul(h, qmul(u2, u));
    csum = 0;
    ssum = 0;
    for (int k = 0; k < NT; k++) begin
      csum += qdiv(ct, 4 * k + 1);
      ssum += qdiv(st, 4 * k + 3);
      ct = qdiv(-qmul(ct, x), (2 * k + 1) * (2 * k + 2));
      st = qdiv(-qmul(st, x), (2 * k + 2) * (2 * k + 3));
    end
    r.c = round_to_field(csum);
    r.s = round_to_field(ssum);
    return r;
  endfunction

  class fresnel_scoreboard;
    fresnel_pair_t pending[$];
    int mismatches = 0;
    int checked = 0;

    function void note_arg(logic [FW-1:0] arg);
      pending.push_back(fresnel_series(arg));
    endfunction

    function void check_pair(logic [FW-1:0] c, logic [FW-1:0] s);
      fresnel_pair_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat c=%h s=%h", c, s);
        return;
      end
      e = pending.pop_front();
      if (e.c !== c || e.s !== s) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp c=%h s=%h, got c=%h s=%h", e.c, e.s, c, s);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fic_in_if  #(.FW(FW)) in_ch ();
  fic_out_if #(.FW(FW)) out_ch ();

  fresnel_integral_pair_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fresnel_scoreboard sb = new();
  int  hold_off = 0;
  int  hold_req = 0;
  int  hold_ack = 0;
  bit  stall_on = 1'b1;
  int  n_sent = 0;

  // note arguments and check results at the accepting edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_arg(in_ch.arg_u);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_pair(out_ch.cos_integral, out_ch.sin_integral);
  end

  // sink: random stalls plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_off <= int'(3 * LAT) - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (!stall_on) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_arg(logic [FW-1:0] a);
    in_ch.valid <= 1'b1;
    in_ch.arg_u <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic idle_cycles(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [FW-1:0] random_arg();
    case ($urandom_range(0, 9))
      0: return FW'($urandom_range(131073, 262143));
      1: return FW'($urandom_range(0, 255));
      2: return FW'($urandom_range(131000, 131072));
      default: return FW'($urandom_range(0, 131072));
    endcase
  endfunction

  initial begin
    logic [FW-1:0] directed[$];
    int            burst;
    in_ch.valid = 1'b0;
    in_ch.arg_u = '0;
    directed = '{0, 1, 2, 255, 256, 32768, 65535, 65536, 65537, 98304, 131071,
                 131072, 131073, 196608, 262142, 262143, 18'h15555, 18'h2AAAA,
                 18'h0AAAA, 18'h3FFFF};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_arg(directed[i]);
    // pause until every expected result is back
    drain_results();

    // fill the pipeline against a stalled sink
    hold_req <= hold_req + 1;
    for (int i = 0; i < 200; i++) send_arg(random_arg());

    stall_on = 1'b1;
    for (int i = 0; i < N_RND; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && i < N_RND; j++, i++) send_arg(random_arg());
      if (i > N_RND / 2) stall_on = 1'b0;
      if (i > 3 * N_RND / 4) stall_on = 1'b1;
      if ($urandom_range(0, 4) != 0) idle_cycles($urandom_range(1, 12));
    end
    drain_results();
    repeat (LAT + 20) @(posedge clk);

    $display("Sent %0d arguments (edges, clamped and random), checked %0d results.",
             n_sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule
